@@ hdl/convex_position_test_defines.svh @@
// Assertion macros shared by the convex position test RTL
`ifndef CONVEX_POSITION_TEST_DEFINES_SVH
`define CONVEX_POSITION_TEST_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset
`define CPT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while in reset
`define CPT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cpt_pkg.sv @@
// Types and constants of the convex position test
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_W        = 32;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = 2 * DIFF_W;
    localparam int COUNT_W        = 6;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // hull sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_C,
        S_GET_C,
        S_TEST,
        S_RD_A_IDX,
        S_RD_A_PT,
        S_CROSS_WAIT,
        S_PUSH,
        S_DONE
    } state_t;

    // cross-product unit phases
    typedef enum logic [1:0] {
        XP_IDLE,
        XP_MUL_L,
        XP_MUL_R,
        XP_CMP
    } xphase_t;

endpackage

`default_nettype wire

@@ hdl/cpt_in_if.sv @@
// Input channel: one point word with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface cpt_in_if import cpt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      has_point;
    logic                      last_point;

    modport source (output valid, x_coord, y_coord, has_point, last_point, input ready);
    modport sink   (input valid, x_coord, y_coord, has_point, last_point, output ready);
endinterface

`default_nettype wire

@@ hdl/cpt_out_if.sv @@
// Result channel: one verdict word with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface cpt_out_if import cpt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               is_convex;
    logic [COUNT_W-1:0] point_count;
    logic               too_many;

    modport source (output valid, is_convex, point_count, too_many, input ready);
    modport sink   (input valid, is_convex, point_count, too_many, output ready);
endinterface

`default_nettype wire

@@ hdl/cpt_cross.sv @@
// Shared cross-product unit: one multiplier used twice, then a signed compare
`timescale 1ns / 1ps
`default_nettype none

module cpt_cross import cpt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire point_t a_pt,
    input  wire point_t b_pt,
    input  wire point_t c_pt,
    output logic        done,
    output logic        not_left
);

    xphase_t phase_reg, phase_next;

    logic signed [DIFF_W-1:0] dbx_reg, dby_reg, dcx_reg, dcy_reg;
    logic signed [PROD_W-1:0] l_reg, r_reg;
    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // phase sequence: capture diffs, left product, right product, compare
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            XP_IDLE:  if (start) phase_next = XP_MUL_L;
            XP_MUL_L: phase_next = XP_MUL_R;
            XP_MUL_R: phase_next = XP_CMP;
            XP_CMP:   phase_next = XP_IDLE;
            default:  phase_next = XP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= XP_IDLE;
        else
            phase_reg <= phase_next;
    end

    // the single multiplier: (bx-ax)*(cy-ay), then (by-ay)*(cx-ax)
    assign mul_a = (phase_reg == XP_MUL_L) ? dbx_reg : dby_reg;
    assign mul_b = (phase_reg == XP_MUL_L) ? dcy_reg : dcx_reg;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (phase_reg == XP_IDLE && start)
        begin
            dbx_reg <= DIFF_W'(b_pt.x) - DIFF_W'(a_pt.x);
            dby_reg <= DIFF_W'(b_pt.y) - DIFF_W'(a_pt.y);
            dcx_reg <= DIFF_W'(c_pt.x) - DIFF_W'(a_pt.x);
            dcy_reg <= DIFF_W'(c_pt.y) - DIFF_W'(a_pt.y);
        end
        if (phase_reg == XP_MUL_L)
            l_reg <= prod;
        if (phase_reg == XP_MUL_R)
            r_reg <= prod;
    end

    // cross <= 0 means the turn is not a strict left turn
    assign done     = (phase_reg == XP_CMP);
    assign not_left = (l_reg <= r_reg);

endmodule

`default_nettype wire

@@ hdl/convex_position_test.sv @@
// Convex position test: point store, hull stack and monotone chain sequencer
// Loads one word per cycle while idle; if k <= 2 or the store overflowed, the final word
//   goes to S_DONE. Not ready from the final word until its verdict is loaded.
// Hull run for k >= 3: a candidate passes S_LOAD_C, S_GET_C and S_TEST, a cross-product
//   test S_RD_A_IDX, S_RD_A_PT and S_CROSS_WAIT; a pop goes back to S_TEST.
// Reset clears the sequencer, the point count and the overflow flag; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module convex_position_test import cpt_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    cpt_in_if.sink    points,
    cpt_out_if.source verdict
);

`include "convex_position_test_defines.svh"

    localparam int PT_AW  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int STK_AW = $clog2(2 * MAX_POINTS);
    localparam int CMP_W  = STK_AW + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [STK_AW-1:0] top_reg, top_next;
    logic [STK_AW-1:0] floor_reg, floor_next;
    logic [PT_AW-1:0]  idx_reg, idx_next;
    logic              upper_reg, upper_next;
    logic              convex_reg, convex_next;
    point_t            a_reg, a_next;
    point_t            b_reg, b_next;
    point_t            c_reg, c_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_convex_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_many_reg;

    point_t            pt_mem [MAX_POINTS];
    logic [PT_AW-1:0]  stk_mem [2 * MAX_POINTS];
    point_t            pt_wdata;
    point_t            pt_q;
    logic [PT_AW-1:0]  stk_q;
    logic [PT_AW-1:0]  pt_raddr;
    logic [STK_AW-1:0] stk_raddr;
    logic              pt_we;
    logic              stk_we;
    logic              x_start;
    logic              xp_done;
    logic              xp_not_left;

    logic              in_take;
    logic              out_load;
    logic              store_full;
    logic [CNT_W-1:0]  count_after;
    logic              ovf_after;
    logic              can_pop;
    logic [PT_AW-1:0]  last_idx;

    // handshake terms
    assign points.ready = (state_reg == S_IDLE);
    assign in_take      = points.valid && points.ready;
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || verdict.ready);

    assign store_full  = (count_reg >= CNT_W'(MAX_POINTS));
    assign pt_we       = in_take && points.has_point && !store_full;
    assign count_after = count_reg + CNT_W'(pt_we);
    assign ovf_after   = ovf_reg || (in_take && points.has_point && store_full);
    assign can_pop     = (top_reg >= STK_AW'(2)) && (top_reg > floor_reg);
    assign last_idx    = PT_AW'(count_reg - CNT_W'(1));
    assign pt_wdata    = '{x: points.x_coord, y: points.y_coord};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take && points.last_point)
                begin
                    if (ovf_after || count_after <= CNT_W'(2))
                        state_next = S_DONE;
                    else
                        state_next = S_LOAD_C;
                end
            end
            S_LOAD_C:     state_next = S_GET_C;
            S_GET_C:      state_next = S_TEST;
            S_TEST:       state_next = can_pop ? S_RD_A_IDX : S_PUSH;
            S_RD_A_IDX:   state_next = S_RD_A_PT;
            S_RD_A_PT:    state_next = S_CROSS_WAIT;
            S_CROSS_WAIT:
            begin
                if (xp_done)
                    state_next = xp_not_left ? S_TEST : S_PUSH;
            end
            S_PUSH:
            begin
                if (upper_reg && idx_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_LOAD_C;
            end
            S_DONE:       if (out_load) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // memory ports and unit start
    always_comb
    begin
        pt_raddr  = idx_reg;
        stk_raddr = top_reg - STK_AW'(2);
        stk_we    = 1'b0;
        x_start   = 1'b0;
        case (state_reg)
            S_RD_A_IDX: pt_raddr = stk_q;
            S_RD_A_PT:  x_start  = 1'b1;
            S_PUSH:     stk_we   = 1'b1;
            default:    ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        top_next       = top_reg;
        floor_next     = floor_reg;
        idx_next       = idx_reg;
        upper_next     = upper_reg;
        convex_next    = convex_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        out_valid_next = out_valid_reg && !verdict.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    count_next = count_after;
                    ovf_next   = ovf_after;
                    if (points.last_point)
                    begin
                        convex_next = !ovf_after;
                        top_next    = '0;
                        floor_next  = '0;
                        idx_next    = '0;
                        upper_next  = 1'b0;
                    end
                end
            end
            S_GET_C:
                c_next = pt_q;
            S_RD_A_PT:
                a_next = pt_q;
            S_CROSS_WAIT:
            begin
                // pop: the old second-from-top becomes the top
                if (xp_done && xp_not_left)
                begin
                    top_next = top_reg - STK_AW'(1);
                    b_next   = a_reg;
                end
            end
            S_PUSH:
            begin
                top_next = top_reg + STK_AW'(1);
                b_next   = c_reg;
                if (!upper_reg)
                begin
                    if (idx_reg == last_idx)
                    begin
                        floor_next = top_reg + STK_AW'(1);
                        idx_next   = PT_AW'(count_reg - CNT_W'(2));
                        upper_next = 1'b1;
                    end
                    else
                        idx_next = idx_reg + PT_AW'(1);
                end
                else if (idx_reg == '0)
                    // closed hull holds k+1 entries when every point is a vertex
                    convex_next = (CMP_W'(top_reg) == CMP_W'(count_reg));
                else
                    idx_next = idx_reg - PT_AW'(1);
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            top_reg       <= '0;
            floor_reg     <= '0;
            idx_reg       <= '0;
            upper_reg     <= 1'b0;
            convex_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            top_reg       <= top_next;
            floor_reg     <= floor_next;
            idx_reg       <= idx_next;
            upper_reg     <= upper_next;
            convex_reg    <= convex_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // point coordinates and result word
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        if (out_load)
        begin
            out_convex_reg <= convex_reg;
            out_count_reg  <= COUNT_W'(count_reg);
            out_many_reg   <= ovf_reg;
        end
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[count_reg[PT_AW-1:0]] <= pt_wdata;
        pt_q <= pt_mem[pt_raddr];
    end

    // hull stack of point indices
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[top_reg] <= idx_reg;
        stk_q <= stk_mem[stk_raddr];
    end

    cpt_cross u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (x_start),
        .a_pt     (pt_q),
        .b_pt     (b_reg),
        .c_pt     (c_reg),
        .done     (xp_done),
        .not_left (xp_not_left)
    );

    assign verdict.valid       = out_valid_reg;
    assign verdict.is_convex   = out_convex_reg;
    assign verdict.point_count = out_count_reg;
    assign verdict.too_many    = out_many_reg;

    // checks
    `CPT_ASSERT_NOW(a_stack_bound,
        state_reg != S_IDLE && state_reg != S_DONE,
        CMP_W'(top_reg) < (CMP_W'(count_reg) << 1),
        "hull stack deeper than twice the point count")
    `CPT_ASSERT_NOW(a_cross_sync, xp_done, state_reg == S_CROSS_WAIT,
        "cross-product result outside the wait state")
    `CPT_ASSERT_NEXT(a_set_clear, out_load,
        verdict.valid && count_reg == '0 && !ovf_reg && state_reg == S_IDLE,
        "set not cleared after the verdict was loaded")

endmodule

`default_nettype wire
